>>> rtl/echo_range_window_qualifier_core_defines.svh
// Assertion macros shared by the echo range qualifier RTL.
`ifndef ECHO_RANGE_WINDOW_QUALIFIER_CORE_DEFINES_SVH
`define ECHO_RANGE_WINDOW_QUALIFIER_CORE_DEFINES_SVH

// Checks that a condition implies a property in the same cycle.
`define ERWQ_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("erwq assertion failed");

// Checks that a condition implies a property in the next cycle.
`define ERWQ_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("erwq assertion failed");

`endif

>>> rtl/erwq_pkg.sv
package erwq_pkg;

  localparam int NUM_SENSORS  = 3;
  localparam int WINDOW       = 15;
  localparam int LIVE_SENSORS = (NUM_SENSORS < 3) ? NUM_SENSORS : 3;
  localparam int SLOT_W       = $clog2(WINDOW + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 5;

  localparam logic [2:0] LIVE_MASK = 3'((1 << LIVE_SENSORS) - 1);

  localparam logic [15:0] SHORT_PULSE_US = 16'd10;
  localparam logic [17:0] MCM_PER_CM     = 18'd1000;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_ARM  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_MIN_S0    = 3'd0,
    REG_MAX_S0    = 3'd1,
    REG_MIN_S1    = 3'd2,
    REG_MAX_S1    = 3'd3,
    REG_MIN_S2    = 3'd4,
    REG_MAX_S2    = 3'd5,
    REG_THRESHOLD = 3'd6
  } reg_idx_e;

  localparam logic [5:0] THRESHOLD_RESET = 6'd3;

endpackage

>>> rtl/echo_range_window_qualifier_core.sv
// Echo range window qualifier for up to three ultrasonic echo channels.
// The slave stream carries one beat per item: tuser is the operation (edge
// event or arm command), tdata the sensor, echo level, microsecond timer and
// arm mask. A rising edge of an active sensor stores its start time; a
// falling edge yields a distance (zero when detected), an in-window flag,
// the hit count over the sliding history and a detection flag, which also
// deactivates the sensor. Every accepted beat produces exactly one master
// beat, measured in tuser. Each beat passes through the input register and
// then the result register before its result appears on the master side.
// Throughput is one beat per cycle unless the receiver stalls; the single
// processing stage reads and updates the per-sensor state in the cycle it
// hands its result on. Reset clears the active mask, start times, histories,
// slots and window registers, and loads the hit threshold with three.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and the slave tready drops until the result is taken.
// The APB port writes and reads the window and threshold registers at byte
// addresses four times the register index; writes are meant for idle time.
`include "echo_range_window_qualifier_core_defines.svh"

module echo_range_window_qualifier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: sensor[1:0], echo_level[2], timer_count[18:3], arm_mask[21:19].
  input  logic [erwq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: operation[0].
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: sensor_id[1:0], distance_mcm[22:2], in_window[23],
  // hit_count[29:24], detected[30], active_now[33:31].
  output logic [erwq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: measured[0].
  output logic                            m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [erwq_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import erwq_pkg::*;

  logic [7:0]        min_q [3];
  logic [7:0]        max_q [3];
  logic [5:0]        thr_q;
  logic [2:0]        active_q;
  logic [15:0]       start_q [LIVE_SENSORS];
  logic [WINDOW-1:0] hist_q  [LIVE_SENSORS];
  logic [SLOT_W-1:0] slot_q  [LIVE_SENSORS];

  logic                 in_valid_q;
  logic                 in_user_q;
  logic [IN_DATA_W-1:0] in_data_q;
  logic                  out_valid_q;
  logic                  out_user_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic advance;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  op_e        op;
  logic [1:0] sensor;
  logic       level;
  logic [15:0] now;
  logic [2:0]  arm;
  logic [LIVE_SENSORS-1:0] sel;
  logic        live;
  logic [15:0] cur_start;
  logic [WINDOW-1:0] cur_hist;
  logic [SLOT_W-1:0] cur_slot;
  logic [7:0]  cur_min;
  logic [7:0]  cur_max;
  logic [15:0] pulse;
  logic [20:0] dist_mcm;
  logic [17:0] lo_mcm;
  logic [17:0] hi_mcm;
  logic        inwin;
  logic [SLOT_W-1:0] slot_eff;
  logic [SLOT_W-1:0] slot_d;
  logic [WINDOW-1:0] hist_d;
  logic [5:0]  hits;
  logic        measured;
  logic        det;
  logic [2:0]  active_d;
  logic [OUT_DATA_W-1:0] out_data_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (reg_idx_e'(cfg_idx))
      REG_MIN_S0:    prdata = {24'd0, min_q[0]};
      REG_MAX_S0:    prdata = {24'd0, max_q[0]};
      REG_MIN_S1:    prdata = {24'd0, min_q[1]};
      REG_MAX_S1:    prdata = {24'd0, max_q[1]};
      REG_MIN_S2:    prdata = {24'd0, min_q[2]};
      REG_MAX_S2:    prdata = {24'd0, max_q[2]};
      REG_THRESHOLD: prdata = {26'd0, thr_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        min_q[k] <= '0;
        max_q[k] <= '0;
      end
      thr_q <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_e'(cfg_idx))
        REG_MIN_S0:    min_q[0] <= pwdata[7:0];
        REG_MAX_S0:    max_q[0] <= pwdata[7:0];
        REG_MIN_S1:    min_q[1] <= pwdata[7:0];
        REG_MAX_S1:    max_q[1] <= pwdata[7:0];
        REG_MIN_S2:    min_q[2] <= pwdata[7:0];
        REG_MAX_S2:    max_q[2] <= pwdata[7:0];
        REG_THRESHOLD: thr_q <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  assign op     = op_e'(in_user_q);
  assign sensor = in_data_q[1:0];
  assign level  = in_data_q[2];
  assign now    = in_data_q[18:3];
  assign arm    = in_data_q[21:19];

  always_comb begin
    cur_start = '0;
    cur_hist  = '0;
    cur_slot  = '0;
    cur_min   = '0;
    cur_max   = '0;
    for (int k = 0; k < LIVE_SENSORS; k++) begin
      sel[k] = (sensor == 2'(k));
      if (sel[k]) begin
        cur_start = start_q[k];
        cur_hist  = hist_q[k];
        cur_slot  = slot_q[k];
        cur_min   = min_q[k];
        cur_max   = max_q[k];
      end
    end
  end

  assign live = (op == OP_EDGE) && |(sel & active_q[LIVE_SENSORS-1:0]);

  always_comb begin
    pulse  = (now > cur_start) ? (now - cur_start) : (now - cur_start - 16'd1);
    dist_mcm = (pulse < SHORT_PULSE_US) ? 21'd0 : ({1'b0, pulse, 4'd0} + 21'(pulse));
    lo_mcm = 18'(cur_min) * MCM_PER_CM;
    hi_mcm = 18'(cur_max) * MCM_PER_CM;
    inwin  = (dist_mcm > 21'(lo_mcm)) && (dist_mcm < 21'(hi_mcm));

    slot_eff = (cur_slot >= SLOT_W'(WINDOW)) ? '0 : cur_slot;
    slot_d   = slot_eff + SLOT_W'(1);
    for (int i = 0; i < WINDOW; i++) begin
      hist_d[i] = (slot_eff == SLOT_W'(i)) ? inwin : cur_hist[i];
    end
    hits = '0;
    for (int i = 0; i < WINDOW; i++) begin
      hits = hits + 6'(hist_d[i]);
    end

    measured = live && !level;
    det      = measured && (hits >= thr_q);

    if (op == OP_ARM) begin
      active_d = arm & LIVE_MASK;
    end else if (det) begin
      active_d = active_q & ~(3'd1 << sensor);
    end else begin
      active_d = active_q;
    end

    out_data_d = '0;
    out_data_d[1:0]   = (op == OP_ARM) ? 2'd0 : sensor;
    out_data_d[22:2]  = (measured && !det) ? dist_mcm : 21'd0;
    out_data_d[23]    = measured && inwin;
    out_data_d[29:24] = measured ? hits : 6'd0;
    out_data_d[30]    = det;
    out_data_d[33:31] = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int k = 0; k < LIVE_SENSORS; k++) begin
        start_q[k] <= '0;
        hist_q[k]  <= '0;
        slot_q[k]  <= '0;
      end
    end else if (advance) begin
      active_q <= active_d;
      for (int k = 0; k < LIVE_SENSORS; k++) begin
        if (live && sel[k]) begin
          if (level) begin
            start_q[k] <= now;
          end else begin
            hist_q[k] <= hist_d;
            slot_q[k] <= slot_d;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_user_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_user_q <= measured;
      out_data_q <= out_data_d;
    end
  end

  `ERWQ_ASSERT_IMP(det_needs_measure_a, out_valid_q && out_data_q[30],
                   out_user_q && (out_data_q[22:2] == 21'd0))
  `ERWQ_ASSERT_IMP(idle_fields_zero_a, out_valid_q && !out_user_q,
                   (out_data_q[30:23] == 8'd0) && (out_data_q[22:2] == 21'd0))
  `ERWQ_ASSERT_IMP(hits_in_window_a, out_valid_q, out_data_q[29:24] <= 6'(WINDOW))
  `ERWQ_ASSERT_NXT(input_holds_a, in_valid_q && !advance, in_valid_q)

endmodule
